/* hw/rtl/prrc_pkg.sv */
// ----------------------------------------------------------------------------
// Page run rectangle collector package
// Shared widths, register indexes, beat payload types and the register file
// view used by the collector and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package prrc_pkg;

    // Widths of the page number, page column and configuration port.
    localparam int PAGE_W     = 9;
    localparam int COL_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int COUNT_W    = 14;
    localparam int BLK_IDX_W  = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES_PER_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_CELLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_IDX_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_IDX_MID = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_IDX_HI  = 3'd6;

    typedef struct packed {
        logic [PAGE_W-1:0] base_page;
        logic [COL_W-1:0]  pages_per_row;
        logic              narrow_cells;
        logic [31:0]       keep_mask;
        logic [59:0]       block_index_low;
        logic [59:0]       block_index_mid;
        logic [39:0]       block_index_high;
    } cfg_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page_index;
        logic              page_present;
        logic              last_item;
    } page_beat_t;

    typedef struct packed {
        logic               run_valid;
        logic [11:0]        run_x0;
        logic [15:0]        run_y0;
        logic [11:0]        run_x1;
        logic [15:0]        run_y1;
        logic               collection_done;
        logic [COUNT_W-1:0] run_total;
    } run_beat_t;

endpackage

`default_nettype wire

/* hw/rtl/prrc_chan_if.sv */
// ----------------------------------------------------------------------------
// Page run rectangle collector channel
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface prrc_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* hw/rtl/prrc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Page run rectangle collector register file
// Write-only configuration registers with their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module prrc_cfg_regs
    import prrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cfg_reg.base_page        <= '0;
            cfg_reg.pages_per_row    <= COL_W'(1);
            cfg_reg.narrow_cells     <= 1'b0;
            cfg_reg.keep_mask        <= '1;
            cfg_reg.block_index_low  <= '0;
            cfg_reg.block_index_mid  <= '0;
            cfg_reg.block_index_high <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_PAGE:     cfg_reg.base_page        <= cfg_wdata[PAGE_W-1:0];
                REG_PAGES_PER_ROW: cfg_reg.pages_per_row    <= cfg_wdata[COL_W-1:0];
                REG_NARROW_CELLS:  cfg_reg.narrow_cells     <= cfg_wdata[0];
                REG_BLOCK_MASK:    cfg_reg.keep_mask        <= cfg_wdata[31:0];
                REG_BLOCK_IDX_LO:  cfg_reg.block_index_low  <= cfg_wdata[59:0];
                REG_BLOCK_IDX_MID: cfg_reg.block_index_mid  <= cfg_wdata[59:0];
                REG_BLOCK_IDX_HI:  cfg_reg.block_index_high <= cfg_wdata[39:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hw/rtl/prrc_div.sv */
// ----------------------------------------------------------------------------
// Page run rectangle collector divider
// Restoring divider, one quotient bit per cycle, page offset by page row width.
// ----------------------------------------------------------------------------
`default_nettype none

module prrc_div
    import prrc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PAGE_W-1:0] dividend,
    input  wire logic [COL_W-1:0]  divisor,
    output logic                   done,
    output logic [PAGE_W-1:0]      quotient,
    output logic [COL_W-1:0]       remainder
);

    localparam int CNT_W = $clog2(PAGE_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PAGE_W-1:0] q_reg, q_next;
    logic [COL_W-1:0] acc_reg, acc_next;
    logic [COL_W-1:0] dvs_reg, dvs_next;
    logic [COL_W:0]   trial;
    logic             fits;

    always_comb begin
        trial     = {acc_reg, q_reg[PAGE_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        acc_next  = acc_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(PAGE_W);
            q_next    = dividend;
            acc_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits COL_W bits.
            acc_next = fits ? COL_W'(trial - {1'b0, dvs_reg}) : trial[COL_W-1:0];
            q_next   = {q_reg[PAGE_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        q_reg   <= q_next;
        acc_reg <= acc_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = acc_reg;

endmodule

`default_nettype wire

/* hw/rtl/page_run_rectangle_collector.sv */
// ----------------------------------------------------------------------------
// Page run rectangle collector
// Turns ascending set page numbers of a swizzled surface into pixel rectangles.
// ----------------------------------------------------------------------------
// Each page beat is accepted only while the sequencer is idle and is then
// worked on alone. A present page with a nonzero mask first goes through the
// restoring divider, which splits the page offset into row and column. With
// an all-ones block mask the page then merges into the open run or opens a
// new one. With a partial mask the sequencer walks the block grid one
// position per cycle while no rectangle emission stalls it, a closing column
// included. Each rectangle is held one beat in a staging register
// so that the final result of a set can carry the done flag and run total;
// an emission in which the staging and output registers are both full and
// the sink is not ready stalls the sequencer. The output register lets the
// next page beat be taken while the last result still waits on the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module page_run_rectangle_collector
    import prrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    prrc_chan_if.sink                  pages,
    prrc_chan_if.source                runs
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_PAGE   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_TAIL   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // Looks up the in-page block number of one grid position.
    function automatic logic [BLK_IDX_W-1:0] grid_block(input logic [4:0] pos,
                                                        input cfg_t c);
        logic [159:0] tbl;
        tbl = {c.block_index_high, c.block_index_mid, c.block_index_low};
        return tbl[{3'b000, pos} * 8'd5 +: BLK_IDX_W];
    endfunction

    cfg_t cfg;

    prrc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Divider: the page offset from the base page wraps at the 512-page
    // surface size, which is exactly the 9-bit width of the page number.
    logic              div_start;
    logic              div_done;
    logic [PAGE_W-1:0] div_q;
    logic [COL_W-1:0]  div_r;
    logic [PAGE_W-1:0] page_rel;
    logic [COL_W-1:0]  ppr_eff;

    assign page_rel = pages.payload.page_index - cfg.base_page;
    // A zero row width is treated as one page per row.
    assign ppr_eff  = (cfg.pages_per_row == '0) ? COL_W'(1) : cfg.pages_per_row;

    prrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (page_rel),
        .divisor   (ppr_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Sequencer and run state.
    logic [2:0]         state_reg, state_next;
    logic               last_reg, last_next;
    logic               run_open_reg, run_open_next;
    logic [PAGE_W-1:0]  open_row_reg, open_row_next;
    logic [COL_W-1:0]   open_first_reg, open_first_next;
    logic [COL_W-1:0]   open_last_reg, open_last_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [2:0]         by_reg, by_next;
    logic [3:0]         bx_reg, bx_next;
    logic               in_span_reg, in_span_next;
    logic [2:0]         s0_reg, s0_next;

    // Staging and output registers.
    logic               hold_valid_reg, hold_valid_next;
    run_beat_t          hold_data_reg, hold_data_next;
    logic               out_valid_reg;
    run_beat_t          out_data_reg;
    logic               out_load;
    run_beat_t          out_load_data;
    logic               out_free;

    // Emission request from the sequencer.
    logic               emit_req;
    run_beat_t          emit_data;
    logic               emit_ok;

    // Geometry and datapath terms.
    logic               page_accept;
    logic               mask_full;
    logic               mask_zero;
    logic [3:0]         grid_cols;
    logic [2:0]         grid_last_row;
    logic [4:0]         grid_pos;
    logic               cell_set;
    logic               extends_run;
    logic               step_ok;
    logic [PAGE_W:0]    open_row_p1;
    logic [3:0]         by_p1;
    logic [11:0]        px0;
    logic [15:0]        py0;
    run_beat_t          flush_data;
    run_beat_t          span_data;

    assign page_accept   = pages.valid && pages.ready;
    assign pages.ready   = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || runs.ready;
    assign emit_ok       = !hold_valid_reg || out_free;
    assign mask_full     = (cfg.keep_mask == '1);
    assign mask_zero     = (cfg.keep_mask == '0);
    assign grid_cols     = cfg.narrow_cells ? 4'd4 : 4'd8;
    assign grid_last_row = cfg.narrow_cells ? 3'd7 : 3'd3;
    // Grid position is block row times the column count plus block column.
    assign grid_pos      = cfg.narrow_cells ? {by_reg, bx_reg[1:0]}
                                            : {by_reg[1:0], bx_reg[2:0]};
    // The closing column past the grid never holds a block, so any open span ends.
    assign cell_set      = (bx_reg != grid_cols) &&
                           cfg.keep_mask[grid_block(grid_pos, cfg)];
    assign extends_run   = run_open_reg && (div_q == open_row_reg) &&
                           ({1'b0, div_r} == ({1'b0, open_last_reg} + 7'd1));

    // The open run as a rectangle; pages are 64 pixels wide and 32 or 64 tall.
    assign open_row_p1   = {1'b0, open_row_reg} + 10'd1;
    always_comb begin
        flush_data                 = '0;
        flush_data.run_valid       = 1'b1;
        flush_data.run_x0          = {open_first_reg, 6'b000000};
        flush_data.run_x1          = 12'({{1'b0, open_last_reg} + 7'd1, 6'b000000});
        flush_data.run_y0          = cfg.narrow_cells ? 16'({open_row_reg, 6'b000000})
                                                      : 16'({open_row_reg, 5'b00000});
        flush_data.run_y1          = cfg.narrow_cells ? 16'({open_row_p1, 6'b000000})
                                                      : 16'({open_row_p1, 5'b00000});
    end

    // A span of blocks within the current block row; blocks are 8 or 16 wide.
    assign px0   = {div_r, 6'b000000};
    assign py0   = cfg.narrow_cells ? 16'({div_q, 6'b000000}) : 16'({div_q, 5'b00000});
    assign by_p1 = {1'b0, by_reg} + 4'd1;
    always_comb begin
        span_data           = '0;
        span_data.run_valid = 1'b1;
        span_data.run_x0    = px0 + (cfg.narrow_cells ? 12'({s0_reg, 4'b0000})
                                                      : 12'({s0_reg, 3'b000}));
        span_data.run_x1    = px0 + (cfg.narrow_cells ? 12'({bx_reg, 4'b0000})
                                                      : 12'({bx_reg, 3'b000}));
        span_data.run_y0    = py0 + 16'({by_reg, 3'b000});
        span_data.run_y1    = py0 + 16'({by_p1, 3'b000});
    end

    always_comb begin
        state_next      = state_reg;
        last_next       = last_reg;
        run_open_next   = run_open_reg;
        open_row_next   = open_row_reg;
        open_first_next = open_first_reg;
        open_last_next  = open_last_reg;
        count_next      = count_reg;
        by_next         = by_reg;
        bx_next         = bx_reg;
        in_span_next    = in_span_reg;
        s0_next         = s0_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        out_load        = 1'b0;
        out_load_data   = hold_data_reg;
        emit_req        = 1'b0;
        emit_data       = flush_data;
        div_start       = 1'b0;
        step_ok         = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (page_accept)
                begin
                    last_next = pages.payload.last_item;
                    if (pages.payload.page_present && !mask_zero)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_PAGE;
                end
            end

            ST_PAGE:
            begin
                by_next      = '0;
                bx_next      = '0;
                in_span_next = 1'b0;
                if (mask_full && extends_run)
                begin
                    open_last_next = div_r;
                    state_next     = ST_TAIL;
                end
                else
                begin
                    // Any open run ends here; a partial-mask page never opens one.
                    if (run_open_reg)
                    begin
                        emit_req = 1'b1;
                        step_ok  = emit_ok;
                    end
                    if (step_ok)
                    begin
                        run_open_next   = mask_full;
                        open_row_next   = div_q;
                        open_first_next = div_r;
                        open_last_next  = div_r;
                        state_next      = mask_full ? ST_TAIL : ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!cell_set && in_span_reg)
                begin
                    emit_req  = 1'b1;
                    emit_data = span_data;
                    step_ok   = emit_ok;
                end
                if (step_ok)
                begin
                    if (cell_set && !in_span_reg)
                    begin
                        s0_next = bx_reg[2:0];
                    end
                    in_span_next = cell_set;
                    if (bx_reg == grid_cols)
                    begin
                        bx_next = '0;
                        by_next = 3'(by_p1);
                        if (by_reg == grid_last_row)
                        begin
                            state_next = ST_TAIL;
                        end
                    end
                    else
                    begin
                        bx_next = bx_reg + 4'd1;
                    end
                end
            end

            ST_TAIL:
            begin
                if (last_reg && run_open_reg)
                begin
                    emit_req = 1'b1;
                    step_ok  = emit_ok;
                end
                if (step_ok)
                begin
                    if (last_reg)
                    begin
                        run_open_next = 1'b0;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // The staged rectangle is the item's last result; on the final
                // item it carries the done flag and the total.
                if (hold_valid_reg || last_reg)
                begin
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        if (!hold_valid_reg)
                        begin
                            out_load_data = '0;
                        end
                        out_load_data.collection_done = last_reg;
                        out_load_data.run_total       = last_reg ? count_reg : '0;
                        hold_valid_next = 1'b0;
                        if (last_reg)
                        begin
                            count_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new rectangle pushes the staged one on to the output register.
        if (emit_req && emit_ok)
        begin
            if (hold_valid_reg)
            begin
                out_load      = 1'b1;
                out_load_data = hold_data_reg;
            end
            hold_valid_next = 1'b1;
            hold_data_next  = emit_data;
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_reg       <= 1'b0;
            run_open_reg   <= 1'b0;
            count_reg      <= '0;
            in_span_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            open_row_reg   <= '0;
            open_first_reg <= '0;
            open_last_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            last_reg       <= last_next;
            run_open_reg   <= run_open_next;
            count_reg      <= count_next;
            in_span_reg    <= in_span_next;
            hold_valid_reg <= hold_valid_next;
            open_row_reg   <= open_row_next;
            open_first_reg <= open_first_next;
            open_last_reg  <= open_last_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (runs.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        by_reg        <= by_next;
        bx_reg        <= bx_next;
        s0_reg        <= s0_next;
        hold_data_reg <= hold_data_next;
        if (out_load)
        begin
            out_data_reg <= out_load_data;
        end
    end

    assign runs.valid   = out_valid_reg;
    assign runs.payload = out_data_reg;

    // The staging register is always drained before a new page beat is taken.
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("staged rectangle left behind at idle");

    // A result without a rectangle only ever closes a set.
    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (runs.valid && !runs.payload.run_valid) |-> runs.payload.collection_done)
        else $error("empty result that does not close the set");

    // The divider only finishes while the sequencer waits on it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    // The block grid scan never runs with a whole-page run still open.
    a_scan_no_open_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !run_open_reg)
        else $error("grid scan with an open whole-page run");

endmodule

`default_nettype wire

/* tb/page_rect_checker.sv */
// ----------------------------------------------------------------------------
// Page run rectangle checker
// Mirrors the register file, predicts the rectangle beats of every accepted
// page beat and compares each rectangle beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_rect_checker
    import prrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  page_valid,
    input  logic                  page_ready,
    input  page_beat_t            page_beat,
    input  logic                  rect_valid,
    input  logic                  rect_ready,
    input  run_beat_t             rect_beat,
    output int                    mismatch_count,
    output int                    rects_waiting,
    output int                    rects_seen
);

    localparam int TOTAL_PAGES     = 512;
    localparam int BLOCKS_PER_PAGE = 32;
    localparam int PAGE_PX_W       = 64;
    localparam int BLOCK_PX_H      = 8;
    localparam int LOG_LIMIT       = 10;

    // Register mirror.
    logic [PAGE_W-1:0] mirror_base;
    logic [COL_W-1:0]  mirror_ppr;
    logic              mirror_narrow;
    logic [31:0]       mirror_mask;
    logic [59:0]       mirror_idx_lo;
    logic [59:0]       mirror_idx_mid;
    logic [39:0]       mirror_idx_hi;

    // Open whole-page run and the rectangle count of the current page set.
    bit                run_open;
    logic [PAGE_W-1:0] open_row;
    logic [COL_W-1:0]  open_first_col;
    logic [COL_W-1:0]  open_last_col;
    logic [COUNT_W-1:0] set_rect_count;

    run_beat_t expected_rects[$];

    function automatic logic [BLK_IDX_W-1:0] grid_block(int pos);
        if (pos < 12)
            return mirror_idx_lo[pos*5 +: 5];
        else if (pos < 24)
            return mirror_idx_mid[(pos-12)*5 +: 5];
        return mirror_idx_hi[(pos-24)*5 +: 5];
    endfunction

    function automatic int grid_cols();
        return mirror_narrow ? 4 : 8;
    endfunction

    function automatic int page_px_h();
        return (BLOCKS_PER_PAGE / grid_cols()) * BLOCK_PX_H;
    endfunction

    function automatic string rect_text(run_beat_t r);
        return $sformatf("valid=%0d x0=%0d y0=%0d x1=%0d y1=%0d done=%0d total=%0d",
                         r.run_valid, r.run_x0, r.run_y0, r.run_x1, r.run_y1,
                         r.collection_done, r.run_total);
    endfunction

    task automatic push_rect(int x0, int y0, int x1, int y1);
        run_beat_t r;
        r = '0;
        r.run_valid = 1'b1;
        r.run_x0 = x0[11:0];
        r.run_y0 = y0[15:0];
        r.run_x1 = x1[11:0];
        r.run_y1 = y1[15:0];
        expected_rects = {expected_rects, r};
        if (set_rect_count != COUNT_MAX)
            set_rect_count = set_rect_count + 1'b1;
    endtask

    task automatic close_run();
        int ph;
        ph = page_px_h();
        if (run_open)
        begin
            push_rect(open_first_col * PAGE_PX_W, open_row * ph,
                      (open_last_col + 1) * PAGE_PX_W, (open_row + 1) * ph);
            run_open = 1'b0;
        end
    endtask

    task automatic predict_page_rects(page_beat_t b);
        int first_new;
        int ppr;
        int rel;
        int row;
        int col;
        int ncols;
        int bw;
        int px0;
        int py0;
        int span0;
        bit in_span;
        bit hit;
        run_beat_t r;
        first_new = expected_rects.size();
        if (b.page_present && mirror_mask != 32'd0)
        begin
            ppr = (mirror_ppr == '0) ? 1 : int'(mirror_ppr);
            rel = (int'(b.page_index) + TOTAL_PAGES - int'(mirror_base)) % TOTAL_PAGES;
            row = rel / ppr;
            col = rel % ppr;
            if (mirror_mask == 32'hFFFF_FFFF)
            begin
                if (run_open && row == open_row && col == open_last_col + 1)
                    open_last_col = col[COL_W-1:0];
                else
                begin
                    close_run();
                    run_open = 1'b1;
                    open_row = row[PAGE_W-1:0];
                    open_first_col = col[COL_W-1:0];
                    open_last_col = col[COL_W-1:0];
                end
            end
            else
            begin
                // A partial mask ends any whole-page run before its spans.
                ncols = grid_cols();
                bw = PAGE_PX_W / ncols;
                px0 = col * PAGE_PX_W;
                py0 = row * page_px_h();
                close_run();
                for (int by = 0; by < BLOCKS_PER_PAGE / ncols; by++)
                begin
                    in_span = 1'b0;
                    span0 = 0;
                    for (int bx = 0; bx <= ncols; bx++)
                    begin
                        hit = 1'b0;
                        if (bx < ncols)
                            hit = mirror_mask[grid_block(by * ncols + bx)];
                        if (hit)
                        begin
                            if (!in_span)
                            begin
                                in_span = 1'b1;
                                span0 = bx;
                            end
                        end
                        else if (in_span)
                        begin
                            push_rect(px0 + span0 * bw, py0 + by * BLOCK_PX_H,
                                      px0 + bx * bw, py0 + (by + 1) * BLOCK_PX_H);
                            in_span = 1'b0;
                        end
                    end
                end
            end
        end
        if (b.last_item)
        begin
            close_run();
            if (expected_rects.size() == first_new)
            begin
                r = '0;
                expected_rects = {expected_rects, r};
            end
            r = expected_rects[expected_rects.size() - 1];
            r.collection_done = 1'b1;
            r.run_total = set_rect_count;
            expected_rects[expected_rects.size() - 1] = r;
            run_open = 1'b0;
            set_rect_count = '0;
        end
    endtask

    task automatic check_rect(run_beat_t got);
        run_beat_t want;
        rects_seen++;
        if (expected_rects.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= LOG_LIMIT)
                $display("%0t: rectangle beat with nothing expected: %s",
                         $realtime, rect_text(got));
        end
        else
        begin
            want = expected_rects.pop_front();
            if (got.run_valid !== want.run_valid || got.run_x0 !== want.run_x0 ||
                got.run_y0 !== want.run_y0 || got.run_x1 !== want.run_x1 ||
                got.run_y1 !== want.run_y1 ||
                got.collection_done !== want.collection_done ||
                got.run_total !== want.run_total)
            begin
                mismatch_count++;
                if (mismatch_count <= LOG_LIMIT)
                    $display("%0t: rectangle mismatch\n  expected %s\n  actual   %s",
                             $realtime, rect_text(want), rect_text(got));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_base = '0;
            mirror_ppr = 6'd1;
            mirror_narrow = 1'b0;
            mirror_mask = 32'hFFFF_FFFF;
            mirror_idx_lo = '0;
            mirror_idx_mid = '0;
            mirror_idx_hi = '0;
            run_open = 1'b0;
            open_row = '0;
            open_first_col = '0;
            open_last_col = '0;
            set_rect_count = '0;
            expected_rects.delete();
            mismatch_count = 0;
            rects_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_PAGE:     mirror_base = cfg_wdata[PAGE_W-1:0];
                    REG_PAGES_PER_ROW: mirror_ppr = cfg_wdata[COL_W-1:0];
                    REG_NARROW_CELLS:  mirror_narrow = cfg_wdata[0];
                    REG_BLOCK_MASK:    mirror_mask = cfg_wdata[31:0];
                    REG_BLOCK_IDX_LO:  mirror_idx_lo = cfg_wdata[59:0];
                    REG_BLOCK_IDX_MID: mirror_idx_mid = cfg_wdata[59:0];
                    REG_BLOCK_IDX_HI:  mirror_idx_hi = cfg_wdata[39:0];
                    default: ;
                endcase
            end
            if (page_valid && page_ready)
                predict_page_rects(page_beat);
            if (rect_valid && rect_ready)
                check_rect(rect_beat);
        end
        rects_waiting = expected_rects.size();
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Page run rectangle collector testbench
// Drives page beats and register settings into the collector, lets the
// checker predict and compare every rectangle beat, and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import prrc_pkg::*;

    // Cycles to let pass once nothing is expected, so that an item that
    // makes no rectangle (zero mask, flush-only, open run) has finished in
    // the sequencer. The slowest item is a partial-mask page.
    localparam int SETTLE_CYCLES = 80;

    // Random page beats wanted per idle regime.
    localparam int BEATS_PER_REGIME = 25;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int src_idle_pct  = 17;
    int sink_idle_pct = 52;

    int beats_sent;
    int sets_sent;
    int settings_loaded;

    int mismatch_count;
    int rects_waiting;
    int rects_seen;

    prrc_chan_if #(.payload_t(page_beat_t)) pages_ch ();
    prrc_chan_if #(.payload_t(run_beat_t))  runs_ch ();

    page_run_rectangle_collector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pages     (pages_ch),
        .runs      (runs_ch)
    );

    page_rect_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .page_valid     (pages_ch.valid),
        .page_ready     (pages_ch.ready),
        .page_beat      (pages_ch.payload),
        .rect_valid     (runs_ch.valid),
        .rect_ready     (runs_ch.ready),
        .rect_beat      (runs_ch.payload),
        .mismatch_count (mismatch_count),
        .rects_waiting  (rects_waiting),
        .rects_seen     (rects_seen)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The rectangle sink stalls at random. Its idle share follows the
    // regime that the stimulus process sets.
    initial
    begin
        runs_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            runs_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Hard limit on the run. The slowest correct run is well under a tenth
    // of this, even with every page making seventeen rectangles that each
    // wait out a long sink stall.
    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Offers one page beat, starting and ending at a falling edge. The valid
    // is only ever lowered during a gap, so a back-to-back beat keeps it high
    // without a second assignment in the same time step.
    task automatic send_page(input logic [PAGE_W-1:0] idx, input bit present,
                             input bit last);
        page_beat_t b;
        b.page_index = idx;
        b.page_present = present;
        b.last_item = last;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pages_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pages_ch.valid <= 1'b1;
        pages_ch.payload <= b;
        @(posedge clk);
        while (!pages_ch.ready)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
        if (last)
            sets_sent++;
    endtask

    // Waits until every predicted rectangle beat has come back, then lets
    // the sequencer finish whatever silent work it may still have.
    task automatic wait_idle();
        pages_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (rects_waiting != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all seven registers on back-to-back cycles. The write enable
    // stays high across the burst and drops once at its end.
    task automatic load_settings(input cfg_t s);
        cfg_we <= 1'b1;
        cfg_index <= REG_BASE_PAGE;
        cfg_wdata <= CFG_DATA_W'(s.base_page);
        @(negedge clk);
        cfg_index <= REG_PAGES_PER_ROW;
        cfg_wdata <= CFG_DATA_W'(s.pages_per_row);
        @(negedge clk);
        cfg_index <= REG_NARROW_CELLS;
        cfg_wdata <= CFG_DATA_W'(s.narrow_cells);
        @(negedge clk);
        cfg_index <= REG_BLOCK_MASK;
        cfg_wdata <= CFG_DATA_W'(s.keep_mask);
        @(negedge clk);
        cfg_index <= REG_BLOCK_IDX_LO;
        cfg_wdata <= CFG_DATA_W'(s.block_index_low);
        @(negedge clk);
        cfg_index <= REG_BLOCK_IDX_MID;
        cfg_wdata <= CFG_DATA_W'(s.block_index_mid);
        @(negedge clk);
        cfg_index <= REG_BLOCK_IDX_HI;
        cfg_wdata <= CFG_DATA_W'(s.block_index_high);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_loaded++;
    endtask

    initial
    begin
        cfg_t s;
        int regime;
        int random_beats;
        int target;
        int set_len;
        int kind;
        logic [PAGE_W-1:0] page;

        // Every input starts at a known value.
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BASE_PAGE;
        cfg_wdata = '0;
        pages_ch.valid = 1'b0;
        pages_ch.payload = '0;
        beats_sent = 0;
        sets_sent = 0;
        settings_loaded = 0;
        random_beats = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---------------- Directed part ----------------
        // Register values straight out of reset: one page per row, so two
        // consecutive pages sit in different rows. The closing beat is
        // flush-only and its page number must be ignored.
        send_page(9'd0, 1'b1, 1'b0);
        send_page(9'd1, 1'b1, 1'b0);
        send_page(9'd511, 1'b0, 1'b1);
        wait_idle();

        // Whole-page merging across the wrap of the page range: with the
        // surface starting at page 500, page 0 lands next to page 511.
        s = '0;
        s.base_page = 9'd500;
        s.pages_per_row = 6'd8;
        s.keep_mask = 32'hFFFF_FFFF;
        s.block_index_low = '1;
        s.block_index_mid = '1;
        s.block_index_high = '1;
        load_settings(s);
        send_page(9'd505, 1'b1, 1'b0);
        send_page(9'd506, 1'b1, 1'b0);
        send_page(9'd507, 1'b1, 1'b0);
        send_page(9'd511, 1'b1, 1'b0);
        send_page(9'd0, 1'b1, 1'b0);
        send_page(9'd3, 1'b1, 1'b1);
        wait_idle();

        // Partial mask in the 4-column layout with the widest surface and
        // an identity block table; the last page sits in the bottom row.
        s = '0;
        s.pages_per_row = 6'd63;
        s.narrow_cells = 1'b1;
        s.keep_mask = 32'hF0F0_A5C3;
        for (int k = 0; k < 32; k++)
        begin
            if (k < 12)
                s.block_index_low[k*5 +: 5] = k[4:0];
            else if (k < 24)
                s.block_index_mid[(k-12)*5 +: 5] = k[4:0];
            else
                s.block_index_high[(k-24)*5 +: 5] = k[4:0];
        end
        load_settings(s);
        send_page(9'd0, 1'b1, 1'b0);
        send_page(9'd62, 1'b1, 1'b0);
        send_page(9'd511, 1'b1, 1'b1);
        wait_idle();

        // Mixed masks: a whole-page run is left open, then the mask turns
        // partial (8-column layout, reversed block table, zero pages per
        // row), and the next page must close the run before its spans.
        s = '0;
        s.keep_mask = 32'hFFFF_FFFF;
        for (int k = 0; k < 32; k++)
        begin
            if (k < 12)
                s.block_index_low[k*5 +: 5] = 5'(31 - k);
            else if (k < 24)
                s.block_index_mid[(k-12)*5 +: 5] = 5'(31 - k);
            else
                s.block_index_high[(k-24)*5 +: 5] = 5'(31 - k);
        end
        load_settings(s);
        send_page(9'd10, 1'b1, 1'b0);
        wait_idle();
        s.keep_mask = 32'h6DB6_DB6D;
        load_settings(s);
        send_page(9'd12, 1'b1, 1'b1);
        wait_idle();

        // Zero mask with a run still open: the page adds nothing, but the
        // last item still ends the run.
        s.keep_mask = 32'hFFFF_FFFF;
        load_settings(s);
        send_page(9'd20, 1'b1, 1'b0);
        send_page(9'd21, 1'b1, 1'b0);
        wait_idle();
        s.keep_mask = 32'h0;
        load_settings(s);
        send_page(9'd300, 1'b1, 1'b1);
        // Sets that make no rectangle at all still close with one done beat.
        send_page(9'd0, 1'b0, 1'b1);
        send_page(9'd511, 1'b1, 1'b1);
        wait_idle();

        // Pages out of order: a lower column never extends the open run.
        s = '0;
        s.pages_per_row = 6'd4;
        s.keep_mask = 32'hFFFF_FFFF;
        load_settings(s);
        send_page(9'd9, 1'b1, 1'b0);
        send_page(9'd8, 1'b1, 1'b0);
        send_page(9'd10, 1'b1, 1'b0);
        send_page(9'd11, 1'b1, 1'b1);

        // ---------------- Random part ----------------
        // Three idle regimes: sender light and sink heavy, the reverse, and
        // neither. Each page set gets fresh register values.
        for (regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:
                begin
                    src_idle_pct = 17;
                    sink_idle_pct = 52;
                end
                1:
                begin
                    src_idle_pct = 52;
                    sink_idle_pct = 17;
                end
                default:
                begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            target = random_beats + BEATS_PER_REGIME;
            while (random_beats < target)
            begin
                wait_idle();
                s.base_page = 9'($urandom);
                case ($urandom_range(0, 4))
                    0:       s.pages_per_row = 6'd0;
                    1:       s.pages_per_row = 6'd1;
                    2:       s.pages_per_row = 6'd63;
                    default: s.pages_per_row = 6'($urandom_range(1, 63));
                endcase
                s.narrow_cells = 1'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: s.keep_mask = 32'hFFFF_FFFF;
                    4:          s.keep_mask = 32'h0;
                    5:          s.keep_mask = $urandom & $urandom;
                    6:          s.keep_mask = $urandom | $urandom;
                    default:    s.keep_mask = $urandom;
                endcase
                s.block_index_low = 60'({$urandom, $urandom});
                s.block_index_mid = 60'({$urandom, $urandom});
                s.block_index_high = 40'({$urandom, $urandom});
                load_settings(s);

                // Mostly an ascending walk with short steps, so runs merge
                // and break on row ends; some flush-only beats and some
                // pages thrown in out of order.
                set_len = $urandom_range(1, 8);
                page = 9'($urandom);
                for (int i = 0; i < set_len; i++)
                begin
                    kind = $urandom_range(0, 99);
                    if (kind < 70)
                    begin
                        if ($urandom_range(0, 9) < 7)
                            page = page + 9'd1;
                        else
                            page = page + 9'($urandom_range(2, 70));
                        send_page(page, 1'b1, i == set_len - 1);
                    end
                    else if (kind < 85)
                        send_page(9'($urandom), 1'b0, i == set_len - 1);
                    else
                        send_page(9'($urandom), 1'b1, i == set_len - 1);
                    random_beats++;
                end
            end
        end

        // Drain: nothing left in flight, then a last quiet stretch so that a
        // stray rectangle beat would still be caught.
        wait_idle();

        $display("Run covered %0d page beats in %0d page sets under %0d register loads,",
                 beats_sent, sets_sent, settings_loaded);
        $display("with %0d rectangle beats compared and %0d mismatches.",
                 rects_seen, mismatch_count);
        if (mismatch_count == 0 && rects_waiting == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
